// ===== rtl/core/cgp_pkg.sv =====
package cgp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PLL_FREQ       = 3'd0;
  localparam logic [2:0] CFG_REF_FREQ       = 3'd1;
  localparam logic [2:0] CFG_PLL_BASE_ADDR  = 3'd2;
  localparam logic [2:0] CFG_MS_BASE_ADDR   = 3'd3;
  localparam logic [2:0] CFG_PLL_RESET_ADDR = 3'd4;
  localparam logic [2:0] CFG_CLK_CTRL_ADDR  = 3'd5;
  localparam logic [2:0] CFG_CLK_CTRL_VALUE = 3'd6;

  localparam int CFG_DATA_W = 30;
  localparam int FREQ_W     = 29;

  // Reset values of the configuration registers
  localparam logic [29:0] PLL_FREQ_RST       = 30'd900000000;
  localparam logic [25:0] REF_FREQ_RST       = 26'd25000000;
  localparam logic [7:0]  PLL_BASE_ADDR_RST  = 8'd26;
  localparam logic [7:0]  MS_BASE_ADDR_RST   = 8'd42;
  localparam logic [7:0]  PLL_RESET_ADDR_RST = 8'd177;
  localparam logic [7:0]  CLK_CTRL_ADDR_RST  = 8'd16;
  localparam logic [7:0]  CLK_CTRL_VALUE_RST = 8'd79;

  // Divider encoding constants
  localparam logic [19:0] FRAC_DENOM     = 20'hFFFFF;
  localparam logic [17:0] P1_OFFSET      = 18'd512;
  localparam logic [7:0]  PLL_RESET_DATA = 8'hA0;

  typedef struct packed {
    logic [29:0] pll_freq;
    logic [25:0] ref_freq;
    logic [7:0]  pll_base_addr;
    logic [7:0]  ms_base_addr;
    logic [7:0]  pll_reset_addr;
    logic [7:0]  clk_ctrl_addr;
    logic [7:0]  clk_ctrl_value;
  } cgp_cfg_t;

  typedef struct packed {
    logic              zero;
    logic [FREQ_W-1:0] freq;
  } cgp_req_t;

  typedef struct packed {
    logic        ovf;
    logic [17:0] p1;
    logic [19:0] p2;
  } cgp_enc_t;

  // Byte sel of one eight-register parameter block
  function automatic logic [7:0] cgp_byte(input logic [17:0] p1, input logic [19:0] p2,
                                          input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0: v = FRAC_DENOM[15:8];
      3'd1: v = FRAC_DENOM[7:0];
      3'd2: v = {6'd0, p1[17:16]};
      3'd3: v = p1[15:8];
      3'd4: v = p1[7:0];
      3'd5: v = {FRAC_DENOM[19:16], p2[19:16]};
      3'd6: v = p2[15:8];
      default: v = p2[7:0];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cgp_front.sv =====
module cgp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cgp_pkg::FREQ_W-1:0] out_freq,
  input  logic                      q_full,
  output logic                      push,
  output cgp_pkg::cgp_req_t         req
);

  logic held;

  assign push     = held && !q_full;
  assign in_stall = held && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Classify on entry: a zero frequency can never be divided by
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req.freq <= out_freq;
      req.zero <= (out_freq == '0);
    end
  end

endmodule

// ===== rtl/core/cgp_queue.sv =====
module cgp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cgp_pkg::cgp_req_t wdata,
  input  logic              pop,
  output cgp_pkg::cgp_req_t rdata,
  output logic              full,
  output logic              not_empty
);

  cgp_pkg::cgp_req_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata     = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/cgp_div.sv =====
module cgp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [29:0]               num,
  input  logic [cgp_pkg::FREQ_W-1:0] den,
  output logic                      busy,
  output cgp_pkg::cgp_enc_t         res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INT  = 3'd1;
  localparam logic [2:0] S_FSET = 3'd2;
  localparam logic [2:0] S_FRAC = 3'd3;
  localparam logic [2:0] S_ENCQ = 3'd4;
  localparam logic [2:0] S_ENCP = 3'd5;

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [28:0] rem;
  logic [29:0] sh;
  logic [28:0] dvs;
  logic [7:0]  a;
  logic [7:0]  q;

  logic [29:0] trial;
  logic [29:0] diff;
  logic        ge;
  logic [28:0] rem_step;
  logic [48:0] frac_dvd;
  logic [26:0] b_sc;
  logic [6:0]  q0;
  logic [20:0] r0;

  assign busy = (state != S_IDLE);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, sh[29]};
    ge       = (trial >= {1'b0, dvs});
    diff     = trial - {1'b0, dvs};
    rem_step = ge ? diff[28:0] : trial[28:0];
    frac_dvd = {rem, 20'd0} - {20'd0, rem};
    b_sc     = {sh[19:0], 7'd0};
    q0       = b_sc[26:20];
    r0       = {1'b0, b_sc[19:0]} + {14'd0, q0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_INT;
          end
        end
        S_INT: begin
          if (cnt == 5'd0) begin
            state <= S_FSET;
          end
        end
        S_FSET: state <= S_FRAC;
        S_FRAC: begin
          if (cnt == 5'd0) begin
            state <= S_ENCQ;
          end
        end
        S_ENCQ: state <= S_ENCP;
        S_ENCP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          rem <= '0;
          sh  <= num;
          dvs <= den;
          cnt <= 5'd29;
        end
      end
      S_INT, S_FRAC: begin
        rem <= rem_step;
        sh  <= {sh[28:0], ge};
        cnt <= cnt - 5'd1;
      end
      S_FSET: begin
        // integer quotient is in sh, remainder in rem
        a       <= sh[7:0];
        res.ovf <= |sh[29:8];
        rem     <= frac_dvd[48:20];
        sh      <= {frac_dvd[19:0], 10'd0};
        cnt     <= 5'd19;
      end
      S_ENCQ: begin
        // divide 128*b by 2^20-1: shift estimate plus one correction
        if (r0 >= {1'b0, cgp_pkg::FRAC_DENOM}) begin
          q      <= {1'b0, q0} + 8'd1;
          res.p2 <= r0[19:0] - cgp_pkg::FRAC_DENOM;
        end else begin
          q      <= {1'b0, q0};
          res.p2 <= r0[19:0];
        end
      end
      S_ENCP: begin
        res.p1 <= {3'd0, a, 7'd0} + {10'd0, q} - cgp_pkg::P1_OFFSET;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// ===== rtl/core/cgp_back.sv =====
module cgp_back (
  input  logic              clk,
  input  logic              rst,
  input  cgp_pkg::cgp_cfg_t cfg,
  input  logic              q_not_empty,
  input  cgp_pkg::cgp_req_t q_req,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        reg_addr,
  output logic [7:0]        reg_data,
  output logic              last,
  output logic              error
);

  localparam logic C_IDLE = 1'b0;
  localparam logic C_RUN  = 1'b1;

  localparam logic [4:0] IDX_PLL_RESET = 5'd16;
  localparam logic [4:0] IDX_CLK_CTRL  = 5'd17;

  logic              cstate;
  logic              req_err;
  logic              busy_pll;
  logic              busy_ms;
  cgp_pkg::cgp_enc_t enc_pll;
  cgp_pkg::cgp_enc_t enc_ms;
  logic              land;

  logic              pend_valid;
  logic              pend_err;
  cgp_pkg::cgp_enc_t pend_pll;
  cgp_pkg::cgp_enc_t pend_ms;

  logic              eactive;
  logic [4:0]        idx;
  logic              e_err;
  cgp_pkg::cgp_enc_t e_pll;
  cgp_pkg::cgp_enc_t e_ms;
  logic              load;
  logic              emit_go;
  logic              e_last;
  logic [7:0]        e_addr;
  logic [7:0]        e_data;

  assign pop  = (cstate == C_IDLE) && q_not_empty;
  assign land = (cstate == C_RUN) && !busy_pll && !busy_ms && !pend_valid;

  cgp_div u_div_pll (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   (cfg.pll_freq),
    .den   ({3'd0, cfg.ref_freq}),
    .busy  (busy_pll),
    .res   (enc_pll)
  );

  cgp_div u_div_ms (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   (cfg.pll_freq),
    .den   (q_req.freq),
    .busy  (busy_ms),
    .res   (enc_ms)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate     <= C_IDLE;
      pend_valid <= 1'b0;
    end else begin
      case (cstate)
        C_IDLE: begin
          if (pop) begin
            cstate <= C_RUN;
          end
        end
        default: begin
          if (land) begin
            cstate <= C_IDLE;
          end
        end
      endcase
      if (land) begin
        pend_valid <= 1'b1;
      end else if (load) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_err <= q_req.zero || (cfg.ref_freq == '0);
    end
    if (land) begin
      pend_err <= req_err || enc_pll.ovf || enc_ms.ovf;
      pend_pll <= enc_pll;
      pend_ms  <= enc_ms;
    end
  end

  // Emitter: walk the write list into the output register
  assign load    = !eactive && pend_valid;
  assign emit_go = eactive && (!out_valid || !out_stall);
  assign e_last  = e_err || (idx == IDX_CLK_CTRL);

  always_comb begin
    if (e_err) begin
      e_addr = 8'd0;
      e_data = 8'd0;
    end else if (idx == IDX_PLL_RESET) begin
      e_addr = cfg.pll_reset_addr;
      e_data = cgp_pkg::PLL_RESET_DATA;
    end else if (idx == IDX_CLK_CTRL) begin
      e_addr = cfg.clk_ctrl_addr;
      e_data = cfg.clk_ctrl_value;
    end else if (idx[3]) begin
      e_addr = cfg.ms_base_addr + {5'd0, idx[2:0]};
      e_data = cgp_pkg::cgp_byte(e_ms.p1, e_ms.p2, idx[2:0]);
    end else begin
      e_addr = cfg.pll_base_addr + {5'd0, idx[2:0]};
      e_data = cgp_pkg::cgp_byte(e_pll.p1, e_pll.p2, idx[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eactive   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        eactive <= 1'b1;
      end else if (emit_go && e_last) begin
        eactive <= 1'b0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx   <= 5'd0;
      e_err <= pend_err;
      e_pll <= pend_pll;
      e_ms  <= pend_ms;
    end else if (emit_go) begin
      idx <= idx + 5'd1;
    end
    if (emit_go) begin
      reg_addr <= e_addr;
      reg_data <= e_data;
      last     <= e_last;
      error    <= e_err;
    end
  end

endmodule

// ===== rtl/core/clock_synth_divider_programmer.sv =====
// Clock synthesizer divider programmer. Each request carries a wanted output
// frequency in hertz; the block turns it into the register writes that tune a
// fractional-N synthesizer: eight writes for the PLL feedback divider
// (pll_freq / ref_freq), eight for the output divider (pll_freq / out_freq),
// then a PLL reset write and a clock control write, the last one flagged with
// last. A zero frequency, a zero crystal setting, or an integer divider part
// above 255 gives a single result with error and last set and no writes.
// Both dividers are worked out in parallel by two bit-serial restoring
// dividers: 30 quotient steps, a setup state (S_FSET), 20 fraction steps,
// then the encode states S_ENCQ and S_ENCP. A new request leaves the queue
// only once the previous results have moved into the result buffer, so the
// next request is computed while the previous writes stream out. The 18
// writes of one request stream out one per cycle from an output register
// while out_stall is low. A two-entry queue sits between the accepting
// front end and the compute/emit back end.
// Configuration is written through cfg_wr/cfg_index/cfg_data and must only
// change while idle.
module clock_synth_divider_programmer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [2:0]                   cfg_index,
  input  logic [cgp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cgp_pkg::FREQ_W-1:0]   out_freq,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   reg_addr,
  output logic [7:0]                   reg_data,
  output logic                         last,
  output logic                         error
);

  cgp_pkg::cgp_cfg_t cfg;
  cgp_pkg::cgp_req_t front_req;
  cgp_pkg::cgp_req_t q_req;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_not_empty;

  // Configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pll_freq       <= cgp_pkg::PLL_FREQ_RST;
      cfg.ref_freq       <= cgp_pkg::REF_FREQ_RST;
      cfg.pll_base_addr  <= cgp_pkg::PLL_BASE_ADDR_RST;
      cfg.ms_base_addr   <= cgp_pkg::MS_BASE_ADDR_RST;
      cfg.pll_reset_addr <= cgp_pkg::PLL_RESET_ADDR_RST;
      cfg.clk_ctrl_addr  <= cgp_pkg::CLK_CTRL_ADDR_RST;
      cfg.clk_ctrl_value <= cgp_pkg::CLK_CTRL_VALUE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        cgp_pkg::CFG_PLL_FREQ:       cfg.pll_freq       <= cfg_data;
        cgp_pkg::CFG_REF_FREQ:       cfg.ref_freq       <= cfg_data[25:0];
        cgp_pkg::CFG_PLL_BASE_ADDR:  cfg.pll_base_addr  <= cfg_data[7:0];
        cgp_pkg::CFG_MS_BASE_ADDR:   cfg.ms_base_addr   <= cfg_data[7:0];
        cgp_pkg::CFG_PLL_RESET_ADDR: cfg.pll_reset_addr <= cfg_data[7:0];
        cgp_pkg::CFG_CLK_CTRL_ADDR:  cfg.clk_ctrl_addr  <= cfg_data[7:0];
        cgp_pkg::CFG_CLK_CTRL_VALUE: cfg.clk_ctrl_value <= cfg_data[7:0];
        default: cfg.clk_ctrl_value <= cfg.clk_ctrl_value;
      endcase
    end
  end

  // Front end: take the request and flag a zero frequency
  cgp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_freq (out_freq),
    .q_full   (q_full),
    .push     (push),
    .req      (front_req)
  );

  // Decouple the front end from the long divider run
  cgp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (front_req),
    .pop       (pop),
    .rdata     (q_req),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back end: divide, encode and stream the register writes
  cgp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_req       (q_req),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_addr    (reg_addr),
    .reg_data    (reg_data),
    .last        (last),
    .error       (error)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int FREQ_W = cgp_pkg::FREQ_W;
  localparam int CFG_DATA_W = cgp_pkg::CFG_DATA_W;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_INT_PART = 255;
  // Index 7 maps to no register; a write there must leave everything alone.
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0] DENOM = 32'(cgp_pkg::FRAC_DENOM);
  localparam logic [31:0] P1_BIAS = 32'(cgp_pkg::P1_OFFSET);

  // One register write as the block emits it.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
    logic       err;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [FREQ_W-1:0] out_freq = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic last;
  logic error;

  // Shadow copy of the tuning registers, updated as each write is issued.
  cgp_pkg::cgp_cfg_t tune_cfg = '{cgp_pkg::PLL_FREQ_RST, cgp_pkg::REF_FREQ_RST,
                                  cgp_pkg::PLL_BASE_ADDR_RST, cgp_pkg::MS_BASE_ADDR_RST,
                                  cgp_pkg::PLL_RESET_ADDR_RST, cgp_pkg::CLK_CTRL_ADDR_RST,
                                  cgp_pkg::CLK_CTRL_VALUE_RST};

  logic [FREQ_W-1:0] freq_q[$];       // frequencies waiting to be sent
  reg_write_t        reg_write_q[$];  // register writes still owed by the block

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Directed frequencies at reset tuning (900 MHz VCO): zero, divider
  // right at and just past the 255 limit, exact integer ratios, integer
  // part below four (P1 wraps), the widest field value and the top bit.
  int unsigned directed_f[$] = '{0, 1, 7, 255, 3515625, 3515626, 3529411, 3529412,
                                 4000000, 7777777, 10000000, 25000000, 33333333,
                                 100000000, 112500000, 123456789, 150000000,
                                 225000000, 225000001, 268435456, 300000000,
                                 300000001, 536870911, 0};

  clock_synth_divider_programmer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_freq  (out_freq),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reg_addr  (reg_addr),
    .reg_data  (reg_data),
    .last      (last),
    .error     (error)
  );

  always #2 clk = ~clk;

  // Append one owed write to the expectation store.
  function automatic void push_write(input logic [7:0] a, input logic [7:0] d,
                                     input logic l, input logic e);
    reg_write_q.push_back('{addr: a, data: d, last: l, err: e});
  endfunction

  // Encode num/den as a fractional-N divider (a + b/c, c fixed) and owe the
  // eight parameter writes starting at base. Addresses wrap at 256.
  function automatic void encode_divider(input logic [7:0] base, input logic [31:0] num,
                                         input logic [31:0] den);
    logic [31:0] a, rem, b, q, p1, p2;
    logic [63:0] frac;
    a = num / den;
    rem = num % den;
    frac = (64'(rem) * 64'(DENOM)) / 64'(den);
    b = frac[31:0];
    q = (32'd128 * b) / DENOM;
    p1 = 32'd128 * a + q - P1_BIAS;  // wraps when a is below four
    p2 = 32'd128 * b - DENOM * q;
    push_write(base + 8'd0, DENOM[15:8], 1'b0, 1'b0);
    push_write(base + 8'd1, DENOM[7:0], 1'b0, 1'b0);
    push_write(base + 8'd2, {6'd0, p1[17:16]}, 1'b0, 1'b0);
    push_write(base + 8'd3, p1[15:8], 1'b0, 1'b0);
    push_write(base + 8'd4, p1[7:0], 1'b0, 1'b0);
    push_write(base + 8'd5, {DENOM[19:16], p2[19:16]}, 1'b0, 1'b0);
    push_write(base + 8'd6, p2[15:8], 1'b0, 1'b0);
    push_write(base + 8'd7, p2[7:0], 1'b0, 1'b0);
  endfunction

  // Work out every write one accepted request owes under the current tuning.
  function automatic void predict_request(input logic [FREQ_W-1:0] f);
    logic [31:0] f32, pll, xtal;
    f32 = 32'(f);
    pll = 32'(tune_cfg.pll_freq);
    xtal = 32'(tune_cfg.ref_freq);
    // Zero divisors are tested first so no division by zero is evaluated.
    if (f32 == 0 || xtal == 0 || pll / xtal > MAX_INT_PART || pll / f32 > MAX_INT_PART) begin
      push_write(8'd0, 8'd0, 1'b1, 1'b1);
    end else begin
      encode_divider(tune_cfg.pll_base_addr, pll, xtal);
      encode_divider(tune_cfg.ms_base_addr, pll, f32);
      push_write(tune_cfg.pll_reset_addr, cgp_pkg::PLL_RESET_DATA, 1'b0, 1'b0);
      push_write(tune_cfg.clk_ctrl_addr, tune_cfg.clk_ctrl_value, 1'b1, 1'b0);
    end
  endfunction

  // Draw a frequency: mostly legal, some full-width, some near the divider
  // limit, some tiny and some zero.
  function automatic logic [FREQ_W-1:0] next_freq();
    int unsigned lo, pick;
    lo = tune_cfg.pll_freq / 255;
    if (lo < 2000) lo = 2000;
    pick = $urandom_range(99);
    if (pick < 70) return FREQ_W'($urandom_range(300000000, lo));
    else if (pick < 80) return FREQ_W'($urandom);
    else if (pick < 88) return FREQ_W'($urandom_range(lo + 1000, lo - 1000));
    else if (pick < 94) return FREQ_W'($urandom_range(1000, 0));
    else return '0;
  endfunction

  // Issue one register write at the next edge and mirror it, masked to width.
  // The caller drops cfg_wr after its last write.
  task automatic write_cfg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      cgp_pkg::CFG_PLL_FREQ:       tune_cfg.pll_freq = val;
      cgp_pkg::CFG_REF_FREQ:       tune_cfg.ref_freq = val[25:0];
      cgp_pkg::CFG_PLL_BASE_ADDR:  tune_cfg.pll_base_addr = val[7:0];
      cgp_pkg::CFG_MS_BASE_ADDR:   tune_cfg.ms_base_addr = val[7:0];
      cgp_pkg::CFG_PLL_RESET_ADDR: tune_cfg.pll_reset_addr = val[7:0];
      cgp_pkg::CFG_CLK_CTRL_ADDR:  tune_cfg.clk_ctrl_addr = val[7:0];
      cgp_pkg::CFG_CLK_CTRL_VALUE: tune_cfg.clk_ctrl_value = val[7:0];
      default: ;
    endcase
  endtask

  task automatic push_freq(input logic [FREQ_W-1:0] f);
    freq_q.push_back(f);
    queued_cnt++;
  endtask

  // Hold until every queued request is accepted and all its writes are back.
  // Counters rather than in_valid avoid racing the driver within an edge.
  task automatic drain();
    while (accepted_cnt != queued_cnt || reg_write_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver: on acceptance, predict the owed writes; whenever the
  // channel is free, present the next frequency or idle at random. A stalled
  // request keeps its valid and payload untouched.
  always @(posedge clk) begin : request_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(out_freq);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (freq_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          out_freq <= freq_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Write monitor: compare each accepted write with the oldest owed one,
  // field by field, and stall the output at random.
  always @(posedge clk) begin : write_monitor
    reg_write_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reg_write_q.size() == 0) begin
          $display("%0t: unexpected write addr %0d data %0d last %0b error %0b",
                   $time, reg_addr, reg_data, last, error);
          mismatches++;
        end else begin
          want = reg_write_q.pop_front();
          if (reg_addr !== want.addr) begin
            $display("%0t: reg_addr expected %0d actual %0d", $time, want.addr, reg_addr);
            mismatches++;
          end
          if (reg_data !== want.data) begin
            $display("%0t: reg_data expected %0d actual %0d", $time, want.data, reg_data);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatches++;
          end
          if (error !== want.err) begin
            $display("%0t: error expected %0b actual %0b", $time, want.err, error);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL clock_synth_divider_programmer");
      $finish;
    end
  end

  // Sequencer: reset, directed requests at reset tuning, then phases that
  // each retune while idle, rotate the idling pattern and send random
  // requests with a full drain halfway through.
  initial begin : sequencer
    logic [CFG_DATA_W-1:0] pll_v, xtal_v, junk;
    logic [7:0] pb, mb, rb, ca, cv;
    int n_items, mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_f[k]) push_freq(FREQ_W'(directed_f[k]));
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      // Rotate: none, sender idle, receiver stall, both lightly.
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 17 : 0;
      recv_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 17 : 0;
      n_items = 55;
      junk = '0;
      pll_v = CFG_DATA_W'($urandom_range(900000000, 600000000));
      xtal_v = CFG_DATA_W'($urandom_range(40000000, 10000000));
      pb = 8'($urandom);
      mb = 8'($urandom);
      rb = 8'($urandom);
      ca = 8'($urandom);
      cv = 8'($urandom);
      case (ph)
        1: begin  // low extremes
          pll_v = 30'd600000000;
          xtal_v = 30'd10000000;
          {pb, mb, rb, ca, cv} = '0;
        end
        2: begin  // high extremes; block addresses wrap past 255
          pll_v = 30'd900000000;
          xtal_v = 30'd40000000;
          {pb, mb, rb, ca, cv} = '1;
        end
        4: begin  // zero crystal: every request errors
          xtal_v = '0;
          n_items = 16;
        end
        5: begin  // feedback integer part of 300: every request errors
          pll_v = 30'd900000000;
          xtal_v = 30'd3000000;
          n_items = 16;
        end
        6: begin  // full-width VCO, junk in the bits above each register
          pll_v = CFG_DATA_W'($urandom);
          junk = CFG_DATA_W'($urandom);
        end
        7: begin  // widest field values
          pll_v = '1;
          xtal_v = 30'h3FFFFFF;
        end
        default: ;
      endcase
      write_cfg(cgp_pkg::CFG_PLL_FREQ, pll_v);
      write_cfg(cgp_pkg::CFG_REF_FREQ, xtal_v | (junk & 30'h3C000000));
      write_cfg(cgp_pkg::CFG_PLL_BASE_ADDR, {junk[21:0], pb});
      write_cfg(cgp_pkg::CFG_MS_BASE_ADDR, {junk[29:8], mb});
      write_cfg(cgp_pkg::CFG_PLL_RESET_ADDR, {junk[21:0], rb});
      write_cfg(cgp_pkg::CFG_CLK_CTRL_ADDR, {junk[29:8], ca});
      write_cfg(cgp_pkg::CFG_CLK_CTRL_VALUE, {junk[21:0], cv});
      if (ph == 4) write_cfg(CFG_UNUSED, CFG_DATA_W'($urandom));
      @(posedge clk);
      cfg_wr <= 1'b0;

      for (int i = 0; i < n_items; i++) begin
        // Pause the sender until all owed writes are back.
        if (i == n_items / 2) drain();
        push_freq(next_freq());
      end
      drain();
    end

    // Let any stray write surface before judging.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS clock_synth_divider_programmer");
    end else begin
      $display("FAIL clock_synth_divider_programmer");
    end
    $finish;
  end

endmodule

// ===== clock_synth_divider_programmer.f =====
rtl/core/cgp_pkg.sv
rtl/core/cgp_front.sv
rtl/core/cgp_queue.sv
rtl/core/cgp_div.sv
rtl/core/cgp_back.sv
rtl/core/clock_synth_divider_programmer.sv
tb/tb_top.sv
